FILE: design/oate_pkg.sv
// ----------------------------------------------------------------------------
// Ordered array table engine package
// Shared constants, request and status codes, and the command and status
// groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package oate_pkg;

  localparam int DEPTH_DEF       = 128;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int MODE_W     = 3;
  localparam int STAT_W     = 3;
  localparam int POS_W      = 8;
  localparam int IN_VAL_W   = 32;
  localparam int OUT_VAL_W  = 32;
  localparam int SUM_W      = 39;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 152;

  // Request codes.
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND = 3'd1;
  localparam logic [MODE_W-1:0] MODE_INSERT = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DELETE = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 3'd4;
  localparam logic [MODE_W-1:0] MODE_UPDATE = 3'd5;
  localparam logic [MODE_W-1:0] MODE_READ   = 3'd6;
  localparam logic [MODE_W-1:0] MODE_AGG    = 3'd7;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_BADPOS   = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic              load;         // latch the accepted item
    logic              commit;       // single-cycle clear, append or update
    logic              scan_start;   // start walking the store
    logic              finish;       // closing write and count change
    logic              load_result;  // fill the output register
    logic [STAT_W-1:0] res_status;
  } oate_cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              pos_zero;
    logic              pos_over;      // position above count
    logic              pos_over_ins;  // position above count plus one
    logic              full;
    logic              empty;
    logic              scan_busy;
    logic              found;
  } oate_stat_t;

endpackage

`default_nettype wire

FILE: design/oate_ctrl.sv
// ----------------------------------------------------------------------------
// Ordered array table engine controller
// Decodes each request against the datapath status and sequences the
// check, scan, finish and result phases; owns the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module oate_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  wire                 out_tready,
  input  oate_pkg::oate_stat_t stat,
  output oate_pkg::oate_cmd_t  cmd
);
  import oate_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_FINISH = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              bad_pos;

  assign bad_pos = stat.pos_zero | stat.pos_over;

  always_comb begin
    state_nxt       = state_r;
    status_nxt      = status_r;
    cmd             = '0;
    cmd.res_status  = status_r;
    in_tready       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        status_nxt = ST_OK;
        state_nxt  = S_DONE;
        unique case (stat.mode)
          MODE_CLEAR: begin
            cmd.commit = 1'b1;
          end
          MODE_APPEND: begin
            if (stat.full) begin
              status_nxt = ST_FULL;
            end else begin
              cmd.commit = 1'b1;
            end
          end
          MODE_INSERT: begin
            if (stat.pos_zero || stat.pos_over_ins) begin
              status_nxt = ST_BADPOS;
            end else if (stat.full) begin
              status_nxt = ST_FULL;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
          MODE_DELETE, MODE_READ: begin
            if (bad_pos) begin
              status_nxt = ST_BADPOS;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
          MODE_UPDATE: begin
            if (bad_pos) begin
              status_nxt = ST_BADPOS;
            end else begin
              cmd.commit = 1'b1;
            end
          end
          MODE_SEARCH: begin
            // An empty store walks no entries and ends as not found.
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end
          MODE_AGG: begin
            if (stat.empty) begin
              status_nxt = ST_EMPTY;
            end else begin
              cmd.scan_start = 1'b1;
              state_nxt      = S_SCAN;
            end
          end
          default: begin
            status_nxt = ST_OK;
          end
        endcase
      end
      S_SCAN: begin
        if (!stat.scan_busy) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        if (stat.mode == MODE_SEARCH) begin
          status_nxt = stat.found ? ST_OK : ST_NOTFOUND;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.load_result = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      status_r    <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      status_r    <= status_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

FILE: design/oate_dp.sv
// ----------------------------------------------------------------------------
// Ordered array table engine datapath
// Element store, count, request registers, the scan engine that walks the
// store one entry a cycle, the search and aggregate units, and the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module oate_dp #(
  parameter int DEPTH       = oate_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = oate_pkg::VALUE_WIDTH_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire        [oate_pkg::MODE_W-1:0]   in_mode,
  input  wire        [oate_pkg::POS_W-1:0]    in_position,
  input  wire signed [oate_pkg::IN_VAL_W-1:0] in_value,
  input  oate_pkg::oate_cmd_t                 cmd,
  output oate_pkg::oate_stat_t                stat,
  output logic       [oate_pkg::STAT_W-1:0]   res_status,
  output logic       [oate_pkg::POS_W-1:0]    res_found_position,
  output logic       [oate_pkg::OUT_VAL_W-1:0] res_element_value,
  output logic       [oate_pkg::OUT_VAL_W-1:0] res_maximum,
  output logic       [oate_pkg::OUT_VAL_W-1:0] res_minimum,
  output logic       [oate_pkg::SUM_W-1:0]    res_total,
  output logic       [oate_pkg::POS_W-1:0]    res_element_count
);
  import oate_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam int EW = 64 - VALUE_WIDTH;

  logic [VALUE_WIDTH-1:0] mem [DEPTH];

  logic [MODE_W-1:0]             mode_r;
  logic [POS_W-1:0]              pos_r;
  logic [VALUE_WIDTH-1:0]        word_r;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [AW-1:0]                 scan_idx_r, scan_idx_nxt;
  logic [CW-1:0]                 scan_left_r, scan_left_nxt;
  logic                          rd_vld_r;
  logic [AW-1:0]                 rd_idx_r;
  logic signed [VALUE_WIDTH-1:0] rd_data_r;
  logic                          found_r, first_r;
  logic [POS_W-1:0]              fpos_r;
  logic signed [VALUE_WIDTH-1:0] max_r, min_r, elem_r;
  logic [SUM_W-1:0]              sum_r;

  logic [63:0]            val_ext, rd_ext, max_ext, min_ext, elem_ext;
  logic [XW-1:0]          pos_x, cnt_x;
  logic                   rd_en;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;
  logic                   res_ok;

  assign val_ext  = {{32{in_value[IN_VAL_W-1]}}, in_value};
  assign rd_ext   = {{EW{rd_data_r[VALUE_WIDTH-1]}}, rd_data_r};
  assign max_ext  = {{EW{max_r[VALUE_WIDTH-1]}}, max_r};
  assign min_ext  = {{EW{min_r[VALUE_WIDTH-1]}}, min_r};
  assign elem_ext = {{EW{elem_r[VALUE_WIDTH-1]}}, elem_r};

  assign pos_x = XW'(pos_r);
  assign cnt_x = XW'(count_r);

  assign stat.mode         = mode_r;
  assign stat.pos_zero     = (pos_r == '0);
  assign stat.pos_over     = (pos_x > cnt_x);
  assign stat.pos_over_ins = (pos_x > cnt_x + XW'(1));
  assign stat.full         = (count_r == CW'(DEPTH));
  assign stat.empty        = (count_r == '0);
  assign stat.scan_busy    = (scan_left_r != '0) | rd_vld_r;
  assign stat.found        = found_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode;
      pos_r  <= in_position;
      word_r <= val_ext[VALUE_WIDTH-1:0];
    end
  end

  // Scan engine: start address and length follow the request.
  assign rd_en = (scan_left_r != '0);

  always_comb begin
    scan_idx_nxt  = scan_idx_r;
    scan_left_nxt = scan_left_r;
    if (cmd.scan_start) begin
      unique case (mode_r)
        MODE_INSERT: begin
          // Walk downward from the last element to the insert position.
          scan_idx_nxt  = AW'(cnt_x - XW'(1));
          scan_left_nxt = CW'(cnt_x - pos_x + XW'(1));
        end
        MODE_DELETE: begin
          scan_idx_nxt  = AW'(pos_x);
          scan_left_nxt = CW'(cnt_x - pos_x);
        end
        MODE_READ: begin
          scan_idx_nxt  = AW'(pos_x - XW'(1));
          scan_left_nxt = CW'(1);
        end
        default: begin
          scan_idx_nxt  = '0;
          scan_left_nxt = count_r;
        end
      endcase
    end else if (rd_en) begin
      scan_idx_nxt  = (mode_r == MODE_INSERT) ? scan_idx_r - AW'(1) : scan_idx_r + AW'(1);
      scan_left_nxt = scan_left_r - CW'(1);
    end
  end

  // Single write port: shifted words during a scan, else the request word.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = word_r;
    priority if (rd_vld_r && mode_r == MODE_INSERT) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx_r + AW'(1);
      wr_data = rd_data_r;
    end else if (rd_vld_r && mode_r == MODE_DELETE) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx_r - AW'(1);
      wr_data = rd_data_r;
    end else if (cmd.commit && mode_r == MODE_APPEND) begin
      wr_en   = 1'b1;
      wr_addr = AW'(count_r);
    end else if ((cmd.commit && mode_r == MODE_UPDATE) ||
                 (cmd.finish && mode_r == MODE_INSERT)) begin
      wr_en   = 1'b1;
      wr_addr = AW'(pos_x - XW'(1));
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[scan_idx_r];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.commit && mode_r == MODE_CLEAR) begin
      count_nxt = '0;
    end else if ((cmd.commit && mode_r == MODE_APPEND) ||
                 (cmd.finish && mode_r == MODE_INSERT)) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.finish && mode_r == MODE_DELETE) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      scan_left_r <= '0;
      rd_vld_r    <= 1'b0;
      found_r     <= 1'b0;
      first_r     <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      scan_left_r <= scan_left_nxt;
      rd_vld_r    <= rd_en;
      if (cmd.scan_start) begin
        found_r <= 1'b0;
        first_r <= 1'b1;
      end else if (rd_vld_r) begin
        first_r <= 1'b0;
        if (mode_r == MODE_SEARCH && !found_r && rd_data_r == word_r) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    if (rd_en) begin
      rd_idx_r <= scan_idx_r;
    end
    if (cmd.scan_start) begin
      sum_r <= '0;
    end else if (rd_vld_r) begin
      // The first match wins; later equal words leave the position alone.
      if (mode_r == MODE_SEARCH && !found_r && rd_data_r == word_r) begin
        fpos_r <= POS_W'(XW'(rd_idx_r) + XW'(1));
      end
      if (mode_r == MODE_READ) begin
        elem_r <= rd_data_r;
      end
      if (first_r || rd_data_r > max_r) begin
        max_r <= rd_data_r;
      end
      if (first_r || rd_data_r < min_r) begin
        min_r <= rd_data_r;
      end
      sum_r <= sum_r + rd_ext[SUM_W-1:0];
    end
  end

  assign res_ok = (cmd.res_status == ST_OK);

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      res_status         <= cmd.res_status;
      res_element_count  <= POS_W'(count_r);
      res_found_position <= (res_ok && mode_r == MODE_SEARCH) ? fpos_r : '0;
      res_element_value  <= (res_ok && mode_r == MODE_READ) ?
                            elem_ext[OUT_VAL_W-1:0] : '0;
      if (res_ok && mode_r == MODE_AGG) begin
        res_maximum <= max_ext[OUT_VAL_W-1:0];
        res_minimum <= min_ext[OUT_VAL_W-1:0];
        res_total   <= sum_r;
      end else begin
        res_maximum <= '0;
        res_minimum <= '0;
        res_total   <= '0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/ordered_array_table_engine_top.sv
// ----------------------------------------------------------------------------
// Ordered array table engine
// Dense ordered array of signed words with clear, append, insert, delete,
// search, update, read and aggregate requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the in_ stream; in_tuser carries the request code and
//   in_tdata the position and value. Each request yields exactly one result
//   item on the out_ stream; out_tuser carries the status code.
//   A request is taken only while the controller is idle, so one request is
//   in work at a time. Clear, append, update and requests refused at the
//   check go from the check straight to the result register. Insert, delete,
//   read, search and aggregates go from the check through a walk over up to
//   DEPTH store entries and a finish step to the result register. The walk
//   reads one store entry a cycle through the single read port of the element
//   memory.
//   The result waits in an output register; the next request is accepted
//   while it waits, and a stalled receiver only holds the engine when the
//   following result is ready to be written.
//   Reset empties the array (count zero) and drops any pending result; the
//   store contents are not cleared and no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_array_table_engine_top #(
  parameter int DEPTH       = oate_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = oate_pkg::VALUE_WIDTH_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // position [7:0], value [39:8]
  input  wire  [oate_pkg::IN_DATA_W-1:0]    in_tdata,
  // mode [2:0]
  input  wire  [oate_pkg::MODE_W-1:0]       in_tuser,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // found_position [7:0], element_value [39:8], maximum [71:40],
  // minimum [103:72], total [142:104], element_count [150:143], zero [151]
  output logic [oate_pkg::OUT_DATA_W-1:0]   out_tdata,
  // status [2:0]
  output logic [oate_pkg::STAT_W-1:0]       out_tuser
);
  import oate_pkg::*;

  oate_cmd_t  cmd;
  oate_stat_t stat;

  logic [POS_W-1:0]     res_found_position;
  logic [OUT_VAL_W-1:0] res_element_value;
  logic [OUT_VAL_W-1:0] res_maximum;
  logic [OUT_VAL_W-1:0] res_minimum;
  logic [SUM_W-1:0]     res_total;
  logic [POS_W-1:0]     res_element_count;

  oate_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  oate_dp #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_mode            (in_tuser),
    .in_position        (in_tdata[7:0]),
    .in_value           (in_tdata[39:8]),
    .cmd                (cmd),
    .stat               (stat),
    .res_status         (out_tuser),
    .res_found_position (res_found_position),
    .res_element_value  (res_element_value),
    .res_maximum        (res_maximum),
    .res_minimum        (res_minimum),
    .res_total          (res_total),
    .res_element_count  (res_element_count)
  );

  assign out_tdata = {1'b0, res_element_count, res_total, res_minimum, res_maximum,
                      res_element_value, res_found_position};

endmodule

`default_nettype wire

FILE: bench/tb_ordered_array_table_engine_top.sv
// ----------------------------------------------------------------------------
// Ordered array table engine testbench
// Sends clear, append, insert, delete, search, update, read and aggregate
// requests, first a directed set and then randomized load profiles. Each
// accepted request is run through a behavioral copy of the table, and every
// result item is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_ordered_array_table_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  import oate_pkg::*;

  localparam int TABLE_DEPTH = DEPTH_DEF;
  localparam int ITEM_TARGET = 1550;
  localparam int STALL_LIMIT = 5000;

  typedef enum int {PROF_GROW, PROF_SHRINK, PROF_MIXED, PROF_FILL} load_profile_t;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  found_pos;
    logic [31:0]       element;
    logic [31:0]       maximum;
    logic [31:0]       minimum;
    logic [SUM_W-1:0]  total;
    logic [7:0]        fill;
  } table_result_t;

  // Behavioral copy of the table plus the queue of results still owed.
  class table_scoreboard;
    logic [31:0]   store [TABLE_DEPTH];
    int unsigned   fill;
    int unsigned   peak_fill;
    table_result_t awaited[$];
    int            errors;
    int            checked;
    int            mode_hits [8];
    int            status_hits [8];

    function new();
      fill = 0;
      peak_fill = 0;
      errors = 0;
      checked = 0;
      foreach (mode_hits[i]) mode_hits[i] = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function void note_request(logic [MODE_W-1:0] mode, logic [POS_W-1:0] pos,
                               logic [31:0] val);
      table_result_t r;
      longint        acc;
      int            i;
      r.mode      = mode;
      r.status    = ST_OK;
      r.found_pos = '0;
      r.element   = '0;
      r.maximum   = '0;
      r.minimum   = '0;
      r.total     = '0;
      acc = 0;
      case (mode)
        MODE_CLEAR: fill = 0;
        MODE_APPEND: begin
          if (fill >= TABLE_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            store[fill] = val;
            fill++;
          end
        end
        MODE_INSERT: begin
          // The position check comes before the capacity check.
          if (pos < 1 || pos > fill + 1) begin
            r.status = ST_BADPOS;
          end else if (fill >= TABLE_DEPTH) begin
            r.status = ST_FULL;
          end else begin
            for (i = fill; i >= pos; i--) store[i] = store[i-1];
            store[pos-1] = val;
            fill++;
          end
        end
        MODE_DELETE: begin
          if (pos < 1 || pos > fill) begin
            r.status = ST_BADPOS;
          end else begin
            for (i = pos - 1; i + 1 < fill; i++) store[i] = store[i+1];
            fill--;
          end
        end
        MODE_SEARCH: begin
          r.status = ST_NOTFOUND;
          for (i = 0; i < fill; i++) begin
            if (store[i] == val) begin
              r.status = ST_OK;
              r.found_pos = POS_W'(i + 1);
              break;
            end
          end
        end
        MODE_UPDATE: begin
          if (pos < 1 || pos > fill) r.status = ST_BADPOS;
          else store[pos-1] = val;
        end
        MODE_READ: begin
          if (pos < 1 || pos > fill) r.status = ST_BADPOS;
          else r.element = store[pos-1];
        end
        default: begin
          if (fill == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.maximum = store[0];
            r.minimum = store[0];
            for (i = 0; i < fill; i++) begin
              if ($signed(store[i]) > $signed(r.maximum)) r.maximum = store[i];
              if ($signed(store[i]) < $signed(r.minimum)) r.minimum = store[i];
              acc += $signed(store[i]);
            end
            r.total = acc[SUM_W-1:0];
          end
        end
      endcase
      r.fill = 8'(fill);
      if (fill > peak_fill) peak_fill = fill;
      mode_hits[mode]++;
      status_hits[r.status]++;
      awaited.push_back(r);
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("%0t ns: mismatch: %s", $time, what);
    endtask

    task compare(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        report($sformatf("result %0d %s: got %0h, want %0h", checked, name, got, want));
    endtask

    task check_result(logic [OUT_DATA_W-1:0] data, logic [STAT_W-1:0] stat);
      table_result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result item with no request outstanding, status %0d", stat));
        return;
      end
      want = awaited.pop_front();
      compare($sformatf("status (mode %0d)", want.mode), stat, want.status);
      compare("found_position", data[7:0], want.found_pos);
      compare("element_value", data[39:8], want.element);
      compare("maximum", data[71:40], want.maximum);
      compare("minimum", data[103:72], want.minimum);
      compare("total", data[142:104], want.total);
      compare("element_count", data[150:143], want.fill);
      compare("padding", data[OUT_DATA_W-1], 1'b0);
      checked++;
    endtask
  endclass

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [MODE_W-1:0]     in_tuser = MODE_CLEAR;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STAT_W-1:0]     out_tuser;

  table_scoreboard book;
  bit              steady = 1'b0;
  int              requests_taken = 0;
  int              quiet_cycles = 0;

  ordered_array_table_engine_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Result side: check each accepted item, then choose the next ready.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) book.check_result(out_tdata, out_tuser);
    out_tready <= steady || ($urandom_range(0, 99) >= 11);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no item moved for %0d cycles, %0d results outstanding.",
                 STALL_LIMIT, book.awaited.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Called in the time step of a rising edge; returns in the step of the
  // edge that accepted the item.
  task automatic send_request(input logic [MODE_W-1:0] mode, input logic [POS_W-1:0] pos,
                              input logic [31:0] val);
    while (!steady && $urandom_range(0, 99) < 11) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {val, pos};
    do @(posedge clk); while (!in_tready);
    book.note_request(mode, pos, val);
    requests_taken++;
  endtask

  // Hold the sender until every result owed has come back.
  task automatic drain_results();
    if (book.awaited.size() != 0) begin
      in_tvalid <= 1'b0;
      while (book.awaited.size() != 0) @(posedge clk);
    end
  endtask

  // Values favor entries already stored so searches hit and duplicates form.
  function automatic logic [31:0] pick_value(bit hunt);
    int roll;
    roll = $urandom_range(0, 99);
    if (book.fill != 0 && roll < (hunt ? 55 : 25))
      return book.store[$urandom_range(0, book.fill - 1)];
    if (roll < (hunt ? 65 : 40)) begin
      case ($urandom_range(0, 4))
        0: return 32'h7FFF_FFFF;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        3: return 32'hFFFF_FFFF;
        default: return 32'h0000_0001;
      endcase
    end
    return $urandom();
  endfunction

  // Mostly legal positions, with the edges just outside and some noise.
  function automatic logic [POS_W-1:0] pick_position(bit for_insert);
    int unsigned top;
    int          roll;
    top  = book.fill + (for_insert ? 1 : 0);
    roll = $urandom_range(0, 99);
    if (roll < 12) return POS_W'($urandom_range(0, 255));
    if (roll < 20 || top == 0) begin
      case ($urandom_range(0, 2))
        0: return '0;
        1: return POS_W'(top);
        default: return POS_W'((top + 1 > 255) ? 255 : top + 1);
      endcase
    end
    return POS_W'($urandom_range(1, top));
  endfunction

  task automatic run_segment(load_profile_t profile, int length);
    int               n;
    int               roll;
    int               style;
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0] pos;
    logic [31:0]      val;
    if (profile == PROF_FILL) begin
      // Pack the table to capacity, then probe append, insert, aggregate, search, read and delete on a full table.
      style = $urandom_range(0, 2);
      while (book.fill < TABLE_DEPTH) begin
        val = (style == 0) ? pick_value(1'b0) :
              (style == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        if ($urandom_range(0, 3) == 0)
          send_request(MODE_INSERT, POS_W'($urandom_range(1, book.fill + 1)), val);
        else
          send_request(MODE_APPEND, POS_W'($urandom_range(0, 255)), val);
      end
      send_request(MODE_APPEND, POS_W'($urandom_range(0, 255)), pick_value(1'b0));
      send_request(MODE_INSERT, POS_W'($urandom_range(1, TABLE_DEPTH + 1)),
                   pick_value(1'b0));
      send_request(MODE_INSERT, POS_W'($urandom_range(TABLE_DEPTH + 2, 255)),
                   pick_value(1'b0));
      send_request(MODE_AGG, POS_W'($urandom_range(0, 255)), $urandom());
      send_request(MODE_SEARCH, POS_W'($urandom_range(0, 255)), pick_value(1'b1));
      send_request(MODE_READ, POS_W'(TABLE_DEPTH), $urandom());
      send_request(MODE_DELETE, POS_W'(TABLE_DEPTH), $urandom());
      return;
    end
    for (n = 0; n < length && requests_taken < ITEM_TARGET; n++) begin
      roll = $urandom_range(0, 99);
      case (profile)
        PROF_GROW:
          mode = roll < 40 ? MODE_APPEND : roll < 65 ? MODE_INSERT :
                 roll < 72 ? MODE_SEARCH : roll < 80 ? MODE_READ :
                 roll < 86 ? MODE_UPDATE : roll < 90 ? MODE_AGG :
                 roll < 96 ? MODE_DELETE : MODE_W'($urandom_range(MODE_CLEAR, MODE_AGG));
        PROF_SHRINK:
          mode = roll < 45 ? MODE_DELETE : roll < 55 ? MODE_READ :
                 roll < 65 ? MODE_SEARCH : roll < 72 ? MODE_UPDATE :
                 roll < 80 ? MODE_AGG : roll < 88 ? MODE_APPEND :
                 roll < 95 ? MODE_INSERT : MODE_W'($urandom_range(MODE_CLEAR, MODE_AGG));
        default:
          mode = roll < 18 ? MODE_APPEND : roll < 34 ? MODE_INSERT :
                 roll < 50 ? MODE_DELETE : roll < 62 ? MODE_SEARCH :
                 roll < 72 ? MODE_UPDATE : roll < 82 ? MODE_READ :
                 roll < 92 ? MODE_AGG : roll < 95 ? MODE_CLEAR :
                 MODE_W'($urandom_range(MODE_CLEAR, MODE_AGG));
      endcase
      case (mode)
        MODE_INSERT: pos = pick_position(1'b1);
        MODE_DELETE, MODE_UPDATE, MODE_READ: pos = pick_position(1'b0);
        default: pos = POS_W'($urandom_range(0, 255));
      endcase
      send_request(mode, pos, pick_value(mode == MODE_SEARCH));
    end
  endtask

  initial begin
    int            seg;
    load_profile_t profile;
    book = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: requests on an empty table, edge values, duplicates, refusals.
    send_request(MODE_AGG, 0, 32'h0000_0000);
    send_request(MODE_SEARCH, 255, 32'h0000_0000);
    send_request(MODE_READ, 1, 32'h0000_0000);
    send_request(MODE_DELETE, 0, 32'h0000_0000);
    send_request(MODE_UPDATE, 255, 32'hFFFF_FFFF);
    send_request(MODE_INSERT, 0, 32'h0000_0005);
    send_request(MODE_INSERT, 2, 32'h0000_0005);
    send_request(MODE_INSERT, 1, 32'h7FFF_FFFF);
    send_request(MODE_APPEND, 255, 32'h8000_0000);
    send_request(MODE_INSERT, 3, 32'hFFFF_FFFF);
    send_request(MODE_INSERT, 1, 32'h0000_0000);
    send_request(MODE_APPEND, 0, 32'hFFFF_FFFF);
    send_request(MODE_READ, 1, 32'h0000_0000);
    send_request(MODE_READ, 5, 32'h0000_0000);
    send_request(MODE_READ, 6, 32'h0000_0000);
    send_request(MODE_SEARCH, 0, 32'hFFFF_FFFF);
    send_request(MODE_SEARCH, 0, 32'h1234_5678);
    send_request(MODE_UPDATE, 2, 32'h5555_5555);
    send_request(MODE_UPDATE, 6, 32'h0000_0001);
    send_request(MODE_AGG, 128, 32'h0000_0000);
    send_request(MODE_DELETE, 5, 32'h0000_0000);
    send_request(MODE_DELETE, 1, 32'h0000_0000);
    send_request(MODE_DELETE, 4, 32'h0000_0000);
    send_request(MODE_CLEAR, 77, 32'hAAAA_AAAA);
    send_request(MODE_AGG, 0, 32'h0000_0000);
    drain_results();

    // Random load profiles; one long segment runs with no idling on either side.
    seg = 0;
    while (requests_taken < ITEM_TARGET) begin
      if ($urandom_range(0, 3) == 0) drain_results();
      steady = (seg == 5);
      if (seg == 2) profile = PROF_FILL;
      else if (seg == 3) profile = PROF_SHRINK;
      else if (seg == 0) profile = PROF_GROW;
      else profile = load_profile_t'($urandom_range(PROF_GROW, PROF_FILL));
      run_segment(profile, steady ? 160 : $urandom_range(30, 110));
      seg++;
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    while (book.awaited.size() != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 16) @(posedge clk);
    if (book.awaited.size() != 0) book.report("results still owed at the end of the run");

    $display("Sent %0d requests: clear %0d, append %0d, insert %0d, delete %0d, search %0d,",
             requests_taken, book.mode_hits[MODE_CLEAR], book.mode_hits[MODE_APPEND],
             book.mode_hits[MODE_INSERT], book.mode_hits[MODE_DELETE],
             book.mode_hits[MODE_SEARCH]);
    $write("update %0d, read %0d, aggregate %0d; %0d results checked, ",
           book.mode_hits[MODE_UPDATE], book.mode_hits[MODE_READ], book.mode_hits[MODE_AGG],
           book.checked);
    $display("%0d full, %0d bad position, %0d missed, %0d empty, peak %0d entries, %0d errors.",
             book.status_hits[ST_FULL], book.status_hits[ST_BADPOS],
             book.status_hits[ST_NOTFOUND], book.status_hits[ST_EMPTY], book.peak_fill,
             book.errors);
    if (book.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
